// File: rtl/ihrt_pkg.sv
// Shared types and constants for the incident history risk table.
// Used by ihrt_ctrl, ihrt_dp and incident_history_risk_table_top; depends on nothing.
package ihrt_pkg;

	localparam int ZONE_W = 16;
	localparam int TYPE_W = 4;
	localparam int COUNT_W = 16;
	localparam int TIME_W = 32;
	localparam int THR_W = 22;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_RISK = 2'd1;
	localparam logic [1:0] CMD_ALARM = 2'd2;

	// Record status codes.
	localparam logic [1:0] REC_UPDATED = 2'd0;
	localparam logic [1:0] REC_INSERTED = 2'd1;
	localparam logic [1:0] REC_FULL = 2'd2;
	localparam logic [1:0] REC_NONE = 2'd3;

	// Risk grades.
	localparam logic [1:0] RISK_LOW = 2'd0;
	localparam logic [1:0] RISK_MEDIUM = 2'd1;
	localparam logic [1:0] RISK_HIGH = 2'd2;
	localparam logic [1:0] RISK_CRITICAL = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STALE = 2'd3;

	localparam logic [THR_W-1:0] CRITICAL_RST = 22'd20;
	localparam logic [THR_W-1:0] HIGH_RST = 22'd10;
	localparam logic [THR_W-1:0] MEDIUM_RST = 22'd5;
	localparam logic [TIME_W-1:0] STALE_RST = 32'd2592000;

	typedef struct packed {
		logic [ZONE_W-1:0] zone;
		logic [TYPE_W-1:0] itype;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0] last_seen;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic scan;
		logic latch_res;
		logic write;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic is_record;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: rtl/ihrt_ctrl.sv
// Controller state machine for the incident history risk table.
// Depends on ihrt_pkg; drives the command struct of ihrt_dp.
module ihrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ihrt_pkg::dp_stat_t stat,
	output ihrt_pkg::ctrl_cmd_t cmd_o
);

	ihrt_pkg::state_t state_q;
	ihrt_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihrt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ihrt_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = ihrt_pkg::ST_SCAN;
			end
			ihrt_pkg::ST_SCAN: begin
				if (stat.done) begin
					state_nxt = stat.is_record ? ihrt_pkg::ST_WRITE : ihrt_pkg::ST_FINISH;
				end
			end
			ihrt_pkg::ST_WRITE: begin
				state_nxt = ihrt_pkg::ST_FINISH;
			end
			ihrt_pkg::ST_FINISH: begin
				if (!stat.out_busy) state_nxt = ihrt_pkg::ST_IDLE;
			end
			default: state_nxt = ihrt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd_o = '0;
		unique case (state_q)
			ihrt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd_o.start = in_valid;
			end
			ihrt_pkg::ST_SCAN: begin
				cmd_o.scan = 1'b1;
				cmd_o.latch_res = stat.done;
			end
			ihrt_pkg::ST_WRITE: begin
				cmd_o.write = 1'b1;
			end
			ihrt_pkg::ST_FINISH: begin
				cmd_o.load_out = !stat.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/ihrt_dp.sv
// Datapath of the incident history risk table: entry memory, scan, grading and output register.
// Depends on ihrt_pkg; sequenced by ihrt_ctrl through command and status structs.
module ihrt_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ihrt_pkg::ctrl_cmd_t                 cmd_i,
	output ihrt_pkg::dp_stat_t                  stat,
	input  logic [1:0]                          cmd,
	input  logic [ihrt_pkg::ZONE_W-1:0]         zone,
	input  logic [ihrt_pkg::TYPE_W-1:0]         incident_type,
	input  logic [ihrt_pkg::TIME_W-1:0]         now_seconds,
	input  logic                                cfg_we,
	input  logic [ihrt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ihrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          record_status,
	output logic [1:0]                          risk_level,
	output logic                                false_alarm
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W = ihrt_pkg::COUNT_W + CNT_W;
	localparam int CMP_W = (SUM_W > ihrt_pkg::THR_W) ? SUM_W : ihrt_pkg::THR_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	// Configuration registers.
	logic [ihrt_pkg::THR_W-1:0]  critical_q, high_q, medium_q;
	logic [ihrt_pkg::TIME_W-1:0] stale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			critical_q <= ihrt_pkg::CRITICAL_RST;
			high_q <= ihrt_pkg::HIGH_RST;
			medium_q <= ihrt_pkg::MEDIUM_RST;
			stale_q <= ihrt_pkg::STALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ihrt_pkg::REG_CRITICAL: critical_q <= cfg_data[ihrt_pkg::THR_W-1:0];
				ihrt_pkg::REG_HIGH:     high_q <= cfg_data[ihrt_pkg::THR_W-1:0];
				ihrt_pkg::REG_MEDIUM:   medium_q <= cfg_data[ihrt_pkg::THR_W-1:0];
				ihrt_pkg::REG_STALE:    stale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latched command item.
	logic [1:0]                  cmd_q;
	logic [ihrt_pkg::ZONE_W-1:0] zone_q;
	logic [ihrt_pkg::TYPE_W-1:0] type_q;
	logic [ihrt_pkg::TIME_W-1:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd_i.start) begin
			cmd_q <= cmd;
			zone_q <= zone;
			type_q <= incident_type;
			now_q <= now_seconds;
		end
	end

	// Entry memory with one write port and one registered read port.
	ihrt_pkg::entry_t ent_mem_q [TABLE_DEPTH];
	ihrt_pkg::entry_t rd_data_s1;
	ihrt_pkg::entry_t wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;
	logic             rd_en;

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] rd_addr_s1;
	logic             pend_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [ihrt_pkg::COUNT_W-1:0] hit_cnt_q;
	logic [ihrt_pkg::TIME_W-1:0]  hit_last_q;
	logic [SUM_W-1:0] sum_q;

	assign rd_en = cmd_i.scan && (rd_idx_q < used_q) && !hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) ent_mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_s1 <= ent_mem_q[rd_idx_q[IDX_W-1:0]];
	end

	logic zone_match;
	logic entry_match;
	logic seek_entry;
	assign zone_match = pend_s1 && (rd_data_s1.zone == zone_q);
	assign entry_match = zone_match && (rd_data_s1.itype == type_q);
	assign seek_entry = (cmd_q == ihrt_pkg::CMD_RECORD) || (cmd_q == ihrt_pkg::CMD_ALARM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			rd_idx_q <= '0;
			pend_s1 <= 1'b0;
			hit_q <= 1'b0;
			sum_q <= '0;
		end else begin
			pend_s1 <= rd_en;
			if (cmd_i.start) begin
				rd_idx_q <= '0;
				hit_q <= 1'b0;
				sum_q <= '0;
			end else begin
				if (rd_en) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (entry_match && seek_entry && !hit_q) hit_q <= 1'b1;
				if (zone_match && cmd_q == ihrt_pkg::CMD_RISK) begin
					sum_q <= sum_q + SUM_W'(rd_data_s1.count);
				end
			end
			if (cmd_i.write && !hit_q && used_q < DEPTH_C) used_q <= used_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_addr_s1 <= rd_idx_q[IDX_W-1:0];
		if (entry_match && seek_entry && !hit_q) begin
			hit_idx_q <= rd_addr_s1;
			hit_cnt_q <= rd_data_s1.count;
			hit_last_q <= rd_data_s1.last_seen;
		end
	end

	// Update or append on a record command.
	always_comb begin
		wr_data.zone = zone_q;
		wr_data.itype = type_q;
		wr_data.last_seen = now_q;
		if (hit_q) begin
			wr_data.count = (hit_cnt_q == ihrt_pkg::COUNT_MAX) ? hit_cnt_q
				: hit_cnt_q + ihrt_pkg::COUNT_W'(1);
			wr_addr = hit_idx_q;
		end else begin
			wr_data.count = ihrt_pkg::COUNT_W'(1);
			wr_addr = used_q[IDX_W-1:0];
		end
		wr_en = cmd_i.write && (hit_q || used_q < DEPTH_C);
	end

	// The scan ends at the first match for record and false-alarm commands,
	// otherwise after the last used entry has been compared.
	assign stat.done = hit_q || (rd_idx_q == used_q && !pend_s1);
	assign stat.is_record = (cmd_q == ihrt_pkg::CMD_RECORD);

	logic [1:0] status_nxt, risk_nxt;
	logic       alarm_nxt;
	logic [ihrt_pkg::TIME_W:0] age;
	logic [CMP_W-1:0] sum_ext;

	assign age = {1'b0, now_q} - {1'b0, hit_last_q};
	assign sum_ext = CMP_W'(sum_q);

	always_comb begin
		status_nxt = ihrt_pkg::REC_NONE;
		risk_nxt = ihrt_pkg::RISK_LOW;
		alarm_nxt = 1'b0;
		case (cmd_q)
			ihrt_pkg::CMD_RECORD: begin
				if (hit_q) status_nxt = ihrt_pkg::REC_UPDATED;
				else if (used_q < DEPTH_C) status_nxt = ihrt_pkg::REC_INSERTED;
				else status_nxt = ihrt_pkg::REC_FULL;
			end
			ihrt_pkg::CMD_RISK: begin
				if (sum_ext > CMP_W'(critical_q)) risk_nxt = ihrt_pkg::RISK_CRITICAL;
				else if (sum_ext > CMP_W'(high_q)) risk_nxt = ihrt_pkg::RISK_HIGH;
				else if (sum_ext > CMP_W'(medium_q)) risk_nxt = ihrt_pkg::RISK_MEDIUM;
				else risk_nxt = ihrt_pkg::RISK_LOW;
			end
			ihrt_pkg::CMD_ALARM: begin
				// A clock that runs behind the entry gives a negative age, never stale.
				alarm_nxt = !hit_q || (hit_cnt_q == ihrt_pkg::COUNT_W'(1) && !age[ihrt_pkg::TIME_W]
					&& age[ihrt_pkg::TIME_W-1:0] > stale_q);
			end
			default: ;
		endcase
	end

	logic [1:0] res_status_q, res_risk_q;
	logic       res_alarm_q;

	always_ff @(posedge clk) begin
		if (cmd_i.latch_res) begin
			res_status_q <= status_nxt;
			res_risk_q <= risk_nxt;
			res_alarm_q <= alarm_nxt;
		end
		if (cmd_i.load_out) begin
			record_status <= res_status_q;
			risk_level <= res_risk_q;
			false_alarm <= res_alarm_q;
		end
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign stat.out_busy = out_valid_q && out_stall;

endmodule

// File: rtl/incident_history_risk_table_top.sv
// Steps: accept, scan of the used entries (ended early by a match for record and false-alarm
// commands), a write for a record command, then a move into the output register.
// One item at a time: the next item is taken once the result has moved to the output
// register, so a stalled result can hold the input off.
// Reset clears the entry count and restores the default thresholds; the entry memory is
// not cleared, since entries beyond the count are never read.
module incident_history_risk_table_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [ihrt_pkg::ZONE_W-1:0]     zone,
	input  logic [ihrt_pkg::TYPE_W-1:0]     incident_type,
	input  logic [ihrt_pkg::TIME_W-1:0]     now_seconds,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      record_status,
	output logic [1:0]                      risk_level,
	output logic                            false_alarm,
	input  logic                            cfg_we,
	input  logic [ihrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ihrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	ihrt_pkg::ctrl_cmd_t ctrl_cmd;
	ihrt_pkg::dp_stat_t  dp_stat;

	ihrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd_o    (ctrl_cmd)
	);

	ihrt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_i         (ctrl_cmd),
		.stat          (dp_stat),
		.cmd           (cmd),
		.zone          (zone),
		.incident_type (incident_type),
		.now_seconds   (now_seconds),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.record_status (record_status),
		.risk_level    (risk_level),
		.false_alarm   (false_alarm)
	);

endmodule
